// ----- src/fqr_pkg.sv -----
// shared types and constants for the id queue with removal by id
// depends on nothing; used by fqr_cell and fifo_queue_with_removal_by_id_unit
package fqr_pkg;

    // default configuration
    localparam int DEPTH_DEF    = 16;
    localparam int ID_WIDTH_DEF = 8;

    // fixed port field widths
    localparam int OP_W     = 2;
    localparam int TID_W    = 8;
    localparam int OUT_ID_W = 8;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    typedef enum logic [OP_W-1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_REMOVE  = 2'd2,
        OP_PEEK    = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // commands broadcast to every cell of the row
    typedef struct packed {
        logic enq;  // append key at the first free cell
        logic deq;  // every cell takes its neighbour's contents
        logic rmv;  // cells at or behind the first match close up
    } t_cell_ctl;

endpackage

// ----- src/fqr_cell.sv -----
// one queue slot: holds an id and a valid bit, shifts towards the head on demand
// depends on fqr_pkg for the cell command struct
module fqr_cell #(
    parameter int ID_WIDTH = fqr_pkg::ID_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fqr_pkg::t_cell_ctl    i_ctl,
    input  logic [ID_WIDTH-1:0]   i_key,
    input  logic                  i_prev_valid,  // cell nearer the head is occupied
    input  logic                  i_next_valid,  // cell nearer the tail
    input  logic [ID_WIDTH-1:0]   i_next_id,
    input  logic                  i_hit,         // match found nearer the head
    output logic                  o_hit,
    output logic                  o_valid,
    output logic [ID_WIDTH-1:0]   o_id
);

    logic                r_valid;
    logic [ID_WIDTH-1:0] r_id;
    logic                n_valid;
    logic [ID_WIDTH-1:0] n_id;
    logic                w_match;
    logic                w_shift;
    logic                w_take;

    assign w_match = r_valid && (r_id == i_key);
    assign o_hit   = i_hit | w_match;
    assign w_shift = i_ctl.deq | (i_ctl.rmv & o_hit);
    assign w_take  = i_ctl.enq & ~r_valid & i_prev_valid;

    always_comb begin
        n_valid = r_valid;
        n_id    = r_id;
        if (w_shift) begin
            n_valid = i_next_valid;
            n_id    = i_next_id;
        end else if (w_take) begin
            n_valid = 1'b1;
            n_id    = i_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id <= n_id;
    end

    assign o_valid = r_valid;
    assign o_id    = r_id;

endmodule

// ----- src/fifo_queue_with_removal_by_id_unit.sv -----
// top level of the id queue: row of fqr_cell slots, occupancy count and result register
// depends on fqr_pkg and fqr_cell
//
// A bounded first-in first-out queue of thread ids, DEPTH entries deep, held
// in a row of cells with the head in cell 0. Each input word carries one
// operation in tuser (enqueue, dequeue, remove by id, peek) and an id in
// tdata. Every word gives exactly one result word: the id dequeued, peeked
// or removed (or the head after a successful enqueue), a status in tuser
// (ok, empty, full, not found) and the occupancy after the operation; the
// id is zero whenever status is not ok. Remove deletes the match nearest the
// head and the later entries close up in order. Each operation completes in
// the cycle it is accepted, all cells comparing their id at once and
// shifting towards the head together, so one word is taken every cycle and
// its result appears in the output register in the next cycle. The length of
// the match chain through the cell row sets the cycle time. A new word is
// taken while the previous result is being read out; only a result held by
// a stalled master side stops the input.
module fifo_queue_with_removal_by_id_unit #(
    parameter int DEPTH    = fqr_pkg::DEPTH_DEF,
    parameter int ID_WIDTH = fqr_pkg::ID_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] thread_id
    input  logic [1:0]  i_s_tuser,   // [1:0] operation
    // master side
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [7:0] out_id, [12:8] occupancy, [15:13] zero
    output logic [1:0]  o_m_tuser    // [1:0] status
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    // cell row wiring
    fqr_pkg::t_cell_ctl  w_ctl;
    logic [ID_WIDTH-1:0] w_key;
    logic [DEPTH-1:0]    w_valid;
    logic [ID_WIDTH-1:0] w_id [DEPTH];
    logic [DEPTH:0]      w_hit;

    // occupancy
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    // result register
    logic                        r_out_valid;
    logic [fqr_pkg::OUT_ID_W-1:0] r_out_id;
    fqr_pkg::t_status            r_status;
    logic [fqr_pkg::OCC_W-1:0]   r_occ;
    logic                        n_out_valid;
    logic [fqr_pkg::OUT_ID_W-1:0] n_out_id;
    fqr_pkg::t_status            n_status;
    logic [fqr_pkg::OCC_W-1:0]   n_occ;

    logic                  w_accept;
    fqr_pkg::t_op          w_op;
    logic                  w_empty;
    logic                  w_full;
    logic [ID_WIDTH-1:0]   w_res_id;
    logic [ID_WIDTH+fqr_pkg::TID_W-1:0]     w_key_ext;
    logic [ID_WIDTH+fqr_pkg::OUT_ID_W-1:0]  w_res_ext;
    logic [CNT_W+fqr_pkg::OCC_W-1:0]        w_occ_ext;

    // input side is free unless a result is stuck on the master side
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;

    assign w_op      = fqr_pkg::t_op'(i_s_tuser);
    // only the low ID_WIDTH bits of the id take part
    assign w_key_ext = {{ID_WIDTH{1'b0}}, i_s_tdata};
    assign w_key     = w_key_ext[ID_WIDTH-1:0];

    assign w_empty = (r_count == '0);
    assign w_full  = (r_count == CNT_W'(DEPTH));

    // commands to the row, gated by acceptance and by the refusal cases
    always_comb begin
        w_ctl = '0;
        if (w_accept) begin
            unique case (w_op)
                fqr_pkg::OP_ENQUEUE: w_ctl.enq = !w_full;
                fqr_pkg::OP_DEQUEUE: w_ctl.deq = !w_empty;
                fqr_pkg::OP_REMOVE:  w_ctl.rmv = !w_empty;
                fqr_pkg::OP_PEEK:    w_ctl     = '0;
                default:             w_ctl     = '0;
            endcase
        end
    end

    // row of cells, head in cell 0; the hit chain runs from the head to the tail
    assign w_hit[0] = 1'b0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                w_prev_valid;
        logic                w_next_valid;
        logic [ID_WIDTH-1:0] w_next_id;

        if (g == 0) begin : g_head
            assign w_prev_valid = 1'b1;
        end else begin : g_body
            assign w_prev_valid = w_valid[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_next_valid = 1'b0;
            assign w_next_id    = '0;
        end else begin : g_inner
            assign w_next_valid = w_valid[g+1];
            assign w_next_id    = w_id[g+1];
        end

        fqr_cell #(
            .ID_WIDTH (ID_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_key        (w_key),
            .i_prev_valid (w_prev_valid),
            .i_next_valid (w_next_valid),
            .i_next_id    (w_next_id),
            .i_hit        (w_hit[g]),
            .o_hit        (w_hit[g+1]),
            .o_valid      (w_valid[g]),
            .o_id         (w_id[g])
        );
    end

    // result and next occupancy
    always_comb begin
        n_count  = r_count;
        n_status = fqr_pkg::ST_OK;
        w_res_id = '0;
        unique case (w_op)
            fqr_pkg::OP_ENQUEUE: begin
                if (w_full) begin
                    n_status = fqr_pkg::ST_FULL;
                end else begin
                    n_count  = r_count + CNT_W'(1);
                    // head after the append: the new id itself on an empty queue
                    w_res_id = w_empty ? w_key : w_id[0];
                end
            end
            fqr_pkg::OP_DEQUEUE: begin
                if (w_empty) begin
                    n_status = fqr_pkg::ST_EMPTY;
                end else begin
                    n_count  = r_count - CNT_W'(1);
                    w_res_id = w_id[0];
                end
            end
            fqr_pkg::OP_REMOVE: begin
                if (w_empty) begin
                    n_status = fqr_pkg::ST_EMPTY;
                end else if (w_hit[DEPTH]) begin
                    n_count  = r_count - CNT_W'(1);
                    w_res_id = w_key;
                end else begin
                    n_status = fqr_pkg::ST_NOT_FOUND;
                end
            end
            fqr_pkg::OP_PEEK: begin
                if (w_empty) begin
                    n_status = fqr_pkg::ST_EMPTY;
                end else begin
                    w_res_id = w_id[0];
                end
            end
            default: begin
                n_status = fqr_pkg::ST_EMPTY;
            end
        endcase
    end

    assign w_res_ext = {{fqr_pkg::OUT_ID_W{1'b0}}, w_res_id};
    assign w_occ_ext = {{fqr_pkg::OCC_W{1'b0}}, n_count};
    assign n_out_id  = w_res_ext[fqr_pkg::OUT_ID_W-1:0];
    assign n_occ     = w_occ_ext[fqr_pkg::OCC_W-1:0];

    // result register: loads on accept, empties when read without a new word
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_accept) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_id <= n_out_id;
            r_status <= n_status;
            r_occ    <= n_occ;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_occ, r_out_id};
    assign o_m_tuser  = r_status;

    // occupancy never goes beyond the row
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("occupancy count beyond depth");

    // occupied cells always match the count
    a_count_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_count))
        else $error("cell valid bits disagree with count");

    // occupied cells form an unbroken run from the head
    a_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid & (w_valid + DEPTH'(1))) == '0)
        else $error("gap in occupied cells");

    // every accepted word leaves a result waiting
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_out_valid)
        else $error("accepted word gave no result");

    // a refused or failed operation reports a zero id
    a_zero_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != fqr_pkg::ST_OK) |-> r_out_id == '0)
        else $error("non-zero id with failing status");

endmodule

// ----- test/id_queue_checker.sv -----
// result checker for the id queue: watches both stream sides, predicts every result word
// depends on fqr_pkg; instantiated by testbench beside the unit
module id_queue_checker #(
    parameter int DEPTH = fqr_pkg::DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] thread_id
    input  logic [1:0]  i_s_tuser,   // [1:0] operation
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,   // [7:0] out_id, [12:8] occupancy, [15:13] zero
    input  logic [1:0]  i_m_tuser,   // [1:0] status
    output int          o_failures,
    output int          o_pending,
    output int          o_checked,
    output int          o_full_seen,
    output int          o_empty_seen,
    output int          o_missing_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0]       id;
        fqr_pkg::t_status status;
        logic [4:0]       occupancy;
    } t_queue_reply;

    // shadow of the queue, head in slot 0
    logic [7:0]   held_ids [DEPTH];
    int           held_count;
    t_queue_reply replies_due [$];

    initial begin
        o_failures     = 0;
        o_pending      = 0;
        o_checked      = 0;
        o_full_seen    = 0;
        o_empty_seen   = 0;
        o_missing_seen = 0;
        held_count     = 0;
    end

    task automatic flag_mismatch(input string what, input int want, input int got);
        o_failures++;
        if (o_failures <= 40) begin
            $display("time %0t: %s expected %0d (0x%0h) got %0d (0x%0h)",
                     $realtime, what, want, want, got, got);
        end
    endtask

    // drop slot pos, later entries move one towards the head
    function automatic void close_gap(input int pos);
        for (int i = pos; i + 1 < held_count; i++) begin
            held_ids[i] = held_ids[i + 1];
        end
        held_count--;
    endfunction

    function automatic t_queue_reply apply_op(input fqr_pkg::t_op op, input logic [7:0] tid);
        t_queue_reply r;
        int hit;
        r.id     = '0;
        r.status = fqr_pkg::ST_OK;
        hit      = -1;
        case (op)
            fqr_pkg::OP_ENQUEUE: begin
                if (held_count >= DEPTH) begin
                    r.status = fqr_pkg::ST_FULL;
                end else begin
                    held_ids[held_count] = tid;
                    held_count++;
                    r.id = held_ids[0];
                end
            end
            fqr_pkg::OP_DEQUEUE: begin
                if (held_count == 0) begin
                    r.status = fqr_pkg::ST_EMPTY;
                end else begin
                    r.id = held_ids[0];
                    close_gap(0);
                end
            end
            fqr_pkg::OP_REMOVE: begin
                if (held_count == 0) begin
                    r.status = fqr_pkg::ST_EMPTY;
                end else begin
                    for (int i = 0; i < held_count; i++) begin
                        if (hit < 0 && held_ids[i] == tid) hit = i;
                    end
                    if (hit < 0) begin
                        r.status = fqr_pkg::ST_NOT_FOUND;
                    end else begin
                        r.id = tid;
                        close_gap(hit);
                    end
                end
            end
            default: begin
                if (held_count == 0) r.status = fqr_pkg::ST_EMPTY;
                else r.id = held_ids[0];
            end
        endcase
        r.occupancy = 5'(held_count);
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_queue_reply want;
        t_queue_reply got;
        if (!i_rst_n) begin
            held_count = 0;
            replies_due.delete();
        end else begin
            // result side first: it always belongs to an earlier word
            if (i_m_tvalid && i_m_tready) begin
                got.id        = i_m_tdata[7:0];
                got.status    = fqr_pkg::t_status'(i_m_tuser);
                got.occupancy = i_m_tdata[12:8];
                o_checked++;
                if (got.status == fqr_pkg::ST_FULL)      o_full_seen++;
                if (got.status == fqr_pkg::ST_EMPTY)     o_empty_seen++;
                if (got.status == fqr_pkg::ST_NOT_FOUND) o_missing_seen++;
                if (replies_due.size() == 0) begin
                    flag_mismatch("unexpected result word, out_id", -1, got.id);
                end else begin
                    want = replies_due.pop_front();
                    if (got.id !== want.id)
                        flag_mismatch("out_id", want.id, got.id);
                    if (got.status !== want.status)
                        flag_mismatch("status", want.status, got.status);
                    if (got.occupancy !== want.occupancy)
                        flag_mismatch("occupancy", want.occupancy, got.occupancy);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                replies_due.push_back(apply_op(fqr_pkg::t_op'(i_s_tuser), i_s_tdata));
            end
        end
        o_pending = replies_due.size();
    end

endmodule

// ----- test/testbench.sv -----
// top of the id queue test: clock, reset, directed and random words, result-side stalls
// depends on fqr_pkg, fifo_queue_with_removal_by_id_unit and id_queue_checker
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LONG_HOLD = 80;   // cycles the result side holds off under pressure

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;   // [7:0] thread_id
    logic [1:0]  i_s_tuser;   // [1:0] operation
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [15:0] o_m_tdata;   // [7:0] out_id, [12:8] occupancy, [15:13] zero
    logic [1:0]  o_m_tuser;   // [1:0] status

    int failures;
    int pending;
    int checked;
    int full_seen;
    int empty_seen;
    int missing_seen;

    // flags shared between the two driving processes, and per-operation word counts
    bit no_idle;    // both sides run without gaps while set
    bit hold_req;   // asks the result side for one long hold-off
    int op_sent [4];

    fifo_queue_with_removal_by_id_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    id_queue_checker u_chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_tvalid     (i_s_tvalid),
        .i_s_tready     (o_s_tready),
        .i_s_tdata      (i_s_tdata),
        .i_s_tuser      (i_s_tuser),
        .i_m_tvalid     (o_m_tvalid),
        .i_m_tready     (i_m_tready),
        .i_m_tdata      (o_m_tdata),
        .i_m_tuser      (o_m_tuser),
        .o_failures     (failures),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_full_seen    (full_seen),
        .o_empty_seen   (empty_seen),
        .o_missing_seen (missing_seen)
    );

    // 4 ns clock
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // hard stop in case the unit hangs
    initial begin
        #1000000;
        $display("fifo_queue_with_removal_by_id_unit verification failed");
        $finish;
    end

    // offer one word after a random gap, return at the falling edge after it is taken;
    // valid stays high straight into the next word when the gap is zero
    task automatic send_word(input fqr_pkg::t_op op, input logic [7:0] tid);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= tid;
        do @(posedge i_clk); while (!o_s_tready);
        op_sent[op]++;
        @(negedge i_clk);
    endtask

    // result side: a fresh stall before each word, or the long hold when asked
    initial begin : result_side
        int stall;
        i_m_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                stall    = LONG_HOLD;
                hold_req = 1'b0;
            end else begin
                stall = no_idle ? 0 : $urandom_range(0, 17);
            end
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        int           enq_weight;
        int           id_base;
        fqr_pkg::t_op op;
        logic [7:0]   tid;

        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = fqr_pkg::OP_ENQUEUE;
        no_idle    = 1'b0;
        hold_req   = 1'b0;
        foreach (op_sent[k]) op_sent[k] = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // everything on an empty queue reports empty, remove included
        send_word(fqr_pkg::OP_PEEK,    8'h00);
        send_word(fqr_pkg::OP_DEQUEUE, 8'hff);
        send_word(fqr_pkg::OP_REMOVE,  8'h00);
        // extreme ids and a duplicate
        send_word(fqr_pkg::OP_ENQUEUE, 8'h00);
        send_word(fqr_pkg::OP_ENQUEUE, 8'hff);
        send_word(fqr_pkg::OP_ENQUEUE, 8'ha5);
        send_word(fqr_pkg::OP_ENQUEUE, 8'hff);
        send_word(fqr_pkg::OP_PEEK,    8'h5a);
        // missing id, then the duplicate nearer the head goes
        send_word(fqr_pkg::OP_REMOVE,  8'h5a);
        send_word(fqr_pkg::OP_REMOVE,  8'hff);
        // fill to the brim, refuse one more, then take out the tail
        for (int k = 0; k < 13; k++) send_word(fqr_pkg::OP_ENQUEUE, 8'h10 + 8'(k));
        send_word(fqr_pkg::OP_ENQUEUE, 8'h77);
        send_word(fqr_pkg::OP_REMOVE,  8'h1c);

        // random phases: filling, draining and balanced mixes over a small id pool,
        // so removes mostly hit and duplicates are common
        for (int phase = 0; phase < 10; phase++) begin
            no_idle = (phase % 4 == 3);
            case (phase % 3)
                0:       enq_weight = 70;
                1:       enq_weight = 25;
                default: enq_weight = 45;
            endcase
            id_base = $urandom_range(0, 244);
            repeat (50) begin
                if ($urandom_range(0, 99) < enq_weight) op = fqr_pkg::OP_ENQUEUE;
                else op = fqr_pkg::t_op'(2'($urandom_range(1, 3)));
                if ($urandom_range(0, 9) == 0) tid = 8'($urandom);
                else tid = 8'(id_base + $urandom_range(0, 11));
                send_word(op, tid);
            end
        end

        // back-pressure: result side stops for a long while, input keeps coming
        hold_req = 1'b1;
        no_idle  = 1'b1;
        repeat (30) begin
            op = ($urandom_range(0, 3) == 0) ? fqr_pkg::OP_PEEK : fqr_pkg::OP_ENQUEUE;
            send_word(op, 8'($urandom));
        end
        no_idle = 1'b0;
        i_s_tvalid <= 1'b0;

        // drain, then wait quietly to catch stray result words
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);

        $display("run: %0d enqueue, %0d dequeue, %0d remove, %0d peek words; %0d results checked",
                 op_sent[fqr_pkg::OP_ENQUEUE], op_sent[fqr_pkg::OP_DEQUEUE],
                 op_sent[fqr_pkg::OP_REMOVE], op_sent[fqr_pkg::OP_PEEK], checked);
        $display("run: %0d refused as full, %0d on empty queue, %0d ids not found",
                 full_seen, empty_seen, missing_seen);
        if (failures == 0) begin
            $display("fifo_queue_with_removal_by_id_unit verification clean");
        end else begin
            $display("fifo_queue_with_removal_by_id_unit verification failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/fqr_pkg.sv
src/fqr_cell.sv
src/fifo_queue_with_removal_by_id_unit.sv
test/id_queue_checker.sv
test/testbench.sv
